FILE: hw/rtl/udpdmx_pkg.sv
// Shared types, codes and constants of the UDP port demultiplexer table.
package udpdmx_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int RES_CAP     = 16;
  localparam int CNT_W       = $clog2(RES_CAP + 1);
  localparam logic [15:0] HDR_BYTES = 16'd8;

  // input item kinds
  localparam logic [1:0] KIND_LISTEN = 2'd0;
  localparam logic [1:0] KIND_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_PACKET = 2'd2;

  // result event codes
  localparam logic [2:0] EV_BOUND   = 3'd0;
  localparam logic [2:0] EV_DELIVER = 3'd1;
  localparam logic [2:0] EV_UNREACH = 3'd2;
  localparam logic [2:0] EV_LISTEN  = 3'd3;
  localparam logic [2:0] EV_FULL    = 3'd4;
  localparam logic [2:0] EV_CLOSED  = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_LISTEN = 4'd2,
    OP_FULL   = 4'd3,
    OP_CLOSE  = 4'd4,
    OP_EVAL   = 4'd5,
    OP_BOUND  = 4'd6,
    OP_DELIV  = 4'd7,
    OP_UNR    = 4'd8,
    OP_FLUSH  = 4'd9
  } op_t;

  typedef struct packed {
    op_t  op;
    logic idx_clr;
    logic idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic cur_used;
    logic bind_hit;
    logic deliv_hit;
    logic bind_hit_r;
    logic deliv_hit_r;
    logic delivered;
    logic pend_valid;
    logic can_gen;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/udpdmx_dp.sv
// Datapath: endpoint table, scan index, result pending stage and output register.
module udpdmx_dp #(
  parameter int ENTRIES = udpdmx_pkg::ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          in_local_port,
  input  logic                 in_deliver_enable,
  input  logic [2:0]           in_slot,
  input  logic [31:0]          in_src_ip,
  input  logic [15:0]          in_src_port,
  input  logic [15:0]          in_dst_port,
  input  logic [15:0]          in_udp_len,
  input  udpdmx_pkg::dp_cmd_t  cmd,
  output udpdmx_pkg::dp_sts_t  sts,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [2:0]           out_event,
  output logic [2:0]           out_entry,
  output logic [15:0]          out_payload_len,
  output logic                 out_last
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EXT_W = IDX_W + 3;

  // latched item fields
  logic [15:0] lport_r;
  logic        den_r;
  logic [2:0]  slot_r;
  logic [31:0] sip_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [15:0] ulen_r;

  logic [IDX_W-1:0]         idx_r;
  logic [udpdmx_pkg::CNT_W-1:0] count_r;
  logic                     delivered_r;
  logic                     bind_hit_r;
  logic                     deliv_hit_r;
  logic [ENTRIES-1:0]       used_r;
  logic [ENTRIES-1:0]       bound_r;
  logic [ENTRIES-1:0]       dlv_r;

  // table memories, registered read at the scan index
  logic [15:0] lport_mem [ENTRIES];
  logic [15:0] pport_mem [ENTRIES];
  logic [31:0] pip_mem   [ENTRIES];
  logic [15:0] rd_lport_r;
  logic [15:0] rd_pport_r;
  logic [31:0] rd_pip_r;

  logic        pend_valid_r;
  logic [2:0]  pend_ev_r;
  logic [2:0]  pend_entry_r;
  logic [15:0] pend_plen_r;

  logic        out_valid_r;
  logic [2:0]  out_ev_r;
  logic [2:0]  out_entry_r;
  logic [15:0] out_plen_r;
  logic        out_last_r;

  logic [EXT_W-1:0] idx_ext;
  logic [EXT_W-1:0] slot_ext;
  logic [15:0]      plen;
  logic             cur_used;
  logic             cur_bound;
  logic             cur_dlv;
  logic             port_eq;
  logic             bind_hit;
  logic             deliv_hit;
  logic             gen_req;
  logic [2:0]       gen_ev;
  logic [2:0]       gen_entry;
  logic [15:0]      gen_plen;
  logic             gen_ok;
  logic             out_free;
  logic             out_load;
  logic             push_last;

  assign idx_ext  = EXT_W'(idx_r);
  assign slot_ext = EXT_W'(slot_r);
  assign plen     = (ulen_r >= udpdmx_pkg::HDR_BYTES) ? (ulen_r - udpdmx_pkg::HDR_BYTES) : '0;

  assign cur_used  = used_r[idx_r];
  assign cur_bound = bound_r[idx_r];
  assign cur_dlv   = dlv_r[idx_r];
  assign port_eq   = (rd_lport_r == dport_r);
  assign bind_hit  = cur_used && !cur_bound && port_eq;
  // a fresh bind stores this packet's source, so it matches at once
  assign deliv_hit = cur_used && cur_dlv && port_eq &&
                     (bind_hit || (cur_bound && (rd_pip_r == sip_r) && (rd_pport_r == sport_r)));

  always_comb begin
    gen_req   = 1'b0;
    gen_ev    = udpdmx_pkg::EV_BOUND;
    gen_entry = '0;
    gen_plen  = '0;
    case (cmd.op)
      udpdmx_pkg::OP_LISTEN: begin
        gen_req   = 1'b1;
        gen_ev    = udpdmx_pkg::EV_LISTEN;
        gen_entry = idx_ext[2:0];
      end
      udpdmx_pkg::OP_FULL: begin
        gen_req = 1'b1;
        gen_ev  = udpdmx_pkg::EV_FULL;
      end
      udpdmx_pkg::OP_CLOSE: begin
        gen_req   = 1'b1;
        gen_ev    = udpdmx_pkg::EV_CLOSED;
        gen_entry = slot_r;
      end
      udpdmx_pkg::OP_BOUND: begin
        gen_req   = 1'b1;
        gen_ev    = udpdmx_pkg::EV_BOUND;
        gen_entry = idx_ext[2:0];
      end
      udpdmx_pkg::OP_DELIV: begin
        gen_req   = 1'b1;
        gen_ev    = udpdmx_pkg::EV_DELIVER;
        gen_entry = idx_ext[2:0];
        gen_plen  = plen;
      end
      udpdmx_pkg::OP_UNR: begin
        gen_req = 1'b1;
        gen_ev  = udpdmx_pkg::EV_UNREACH;
      end
      default: begin
        gen_req = 1'b0;
      end
    endcase
  end

  // drop results beyond the cap; the pending stage keeps the last one kept
  assign gen_ok    = gen_req && (count_r < udpdmx_pkg::CNT_W'(udpdmx_pkg::RES_CAP));
  assign out_free  = !out_valid_r || out_tready;
  assign push_last = (cmd.op == udpdmx_pkg::OP_FLUSH);
  assign out_load  = (gen_ok && pend_valid_r) || push_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      count_r      <= '0;
      delivered_r  <= 1'b0;
      bind_hit_r   <= 1'b0;
      deliv_hit_r  <= 1'b0;
      used_r       <= '0;
      bound_r      <= '0;
      dlv_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end

      if (cmd.op == udpdmx_pkg::OP_LOAD) begin
        count_r     <= '0;
        delivered_r <= 1'b0;
      end else if (gen_ok) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.op == udpdmx_pkg::OP_DELIV) begin
        delivered_r <= 1'b1;
      end

      if (cmd.op == udpdmx_pkg::OP_EVAL) begin
        bind_hit_r  <= bind_hit;
        deliv_hit_r <= deliv_hit;
        if (bind_hit) begin
          bound_r[idx_r] <= 1'b1;
        end
      end

      if (cmd.op == udpdmx_pkg::OP_LISTEN) begin
        used_r[idx_r]  <= 1'b1;
        bound_r[idx_r] <= 1'b0;
        dlv_r[idx_r]   <= den_r;
      end

      if (cmd.op == udpdmx_pkg::OP_CLOSE) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_ext == EXT_W'(i)) begin
            used_r[i]  <= 1'b0;
            bound_r[i] <= 1'b0;
            dlv_r[i]   <= 1'b0;
          end
        end
      end

      if (gen_ok) begin
        pend_valid_r <= 1'b1;
      end else if (push_last) begin
        pend_valid_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == udpdmx_pkg::OP_LOAD) begin
      lport_r <= in_local_port;
      den_r   <= in_deliver_enable;
      slot_r  <= in_slot;
      sip_r   <= in_src_ip;
      sport_r <= in_src_port;
      dport_r <= in_dst_port;
      ulen_r  <= in_udp_len;
    end
    if (gen_ok) begin
      pend_ev_r    <= gen_ev;
      pend_entry_r <= gen_entry;
      pend_plen_r  <= gen_plen;
    end
    if (out_load) begin
      out_ev_r    <= pend_ev_r;
      out_entry_r <= pend_entry_r;
      out_plen_r  <= pend_plen_r;
      out_last_r  <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == udpdmx_pkg::OP_LISTEN) begin
      lport_mem[idx_r] <= lport_r;
    end
    if ((cmd.op == udpdmx_pkg::OP_EVAL) && bind_hit) begin
      pport_mem[idx_r] <= sport_r;
      pip_mem[idx_r]   <= sip_r;
    end
    rd_lport_r <= lport_mem[idx_r];
    rd_pport_r <= pport_mem[idx_r];
    rd_pip_r   <= pip_mem[idx_r];
  end

  always_comb begin
    sts.idx_last    = (idx_r == IDX_W'(ENTRIES - 1));
    sts.cur_used    = cur_used;
    sts.bind_hit    = bind_hit;
    sts.deliv_hit   = deliv_hit;
    sts.bind_hit_r  = bind_hit_r;
    sts.deliv_hit_r = deliv_hit_r;
    sts.delivered   = delivered_r;
    sts.pend_valid  = pend_valid_r;
    sts.can_gen     = !pend_valid_r || out_free;
    sts.out_free    = out_free;
  end

  assign out_tvalid      = out_valid_r;
  assign out_event       = out_ev_r;
  assign out_entry       = out_entry_r;
  assign out_payload_len = out_plen_r;
  assign out_last        = out_last_r;

endmodule

FILE: hw/rtl/udpdmx_ctrl.sv
// Controller: state machine that sequences listen, close and packet scans.
module udpdmx_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic [1:0]           in_kind,
  output logic                 in_tready,
  input  udpdmx_pkg::dp_sts_t  sts,
  output udpdmx_pkg::dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LSCAN  = 9'b000000010,
    S_CLOSE  = 9'b000000100,
    S_PREAD  = 9'b000001000,
    S_PEVAL  = 9'b000010000,
    S_PBIND  = 9'b000100000,
    S_PDELIV = 9'b001000000,
    S_PUNR   = 9'b010000000,
    S_FLUSH  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = udpdmx_pkg::OP_NONE;
    cmd.idx_clr = 1'b0;
    cmd.idx_inc = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op      = udpdmx_pkg::OP_LOAD;
          cmd.idx_clr = 1'b1;
          case (in_kind)
            udpdmx_pkg::KIND_LISTEN: state_nxt = S_LSCAN;
            udpdmx_pkg::KIND_CLOSE:  state_nxt = S_CLOSE;
            udpdmx_pkg::KIND_PACKET: state_nxt = S_PREAD;
            default:                 state_nxt = S_IDLE;
          endcase
        end
      end
      S_LSCAN: begin
        if (!sts.cur_used) begin
          if (sts.can_gen) begin
            cmd.op    = udpdmx_pkg::OP_LISTEN;
            state_nxt = S_FLUSH;
          end
        end else if (sts.idx_last) begin
          if (sts.can_gen) begin
            cmd.op    = udpdmx_pkg::OP_FULL;
            state_nxt = S_FLUSH;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CLOSE: begin
        if (sts.can_gen) begin
          cmd.op    = udpdmx_pkg::OP_CLOSE;
          state_nxt = S_FLUSH;
        end
      end
      S_PREAD: begin
        state_nxt = S_PEVAL;
      end
      S_PEVAL: begin
        cmd.op = udpdmx_pkg::OP_EVAL;
        if (sts.bind_hit) begin
          state_nxt = S_PBIND;
        end else if (sts.deliv_hit) begin
          state_nxt = S_PDELIV;
        end else if (sts.idx_last) begin
          state_nxt = S_PUNR;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_PREAD;
        end
      end
      S_PBIND: begin
        if (sts.can_gen) begin
          cmd.op = udpdmx_pkg::OP_BOUND;
          if (sts.deliv_hit_r) begin
            state_nxt = S_PDELIV;
          end else if (sts.idx_last) begin
            state_nxt = S_PUNR;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_PREAD;
          end
        end
      end
      S_PDELIV: begin
        if (sts.can_gen) begin
          cmd.op = udpdmx_pkg::OP_DELIV;
          if (sts.idx_last) begin
            state_nxt = S_PUNR;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_PREAD;
          end
        end
      end
      S_PUNR: begin
        if (sts.delivered) begin
          state_nxt = S_FLUSH;
        end else if (sts.can_gen) begin
          cmd.op    = udpdmx_pkg::OP_UNR;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.op    = udpdmx_pkg::OP_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/udp_port_demux_table_top.sv
// Top level of the UDP port demultiplexer table.
//
// Keeps a table of ENTRIES UDP endpoints and answers one input transfer with one or
// more result transfers, the final one marked by out_tlast. A listen item (in_tuser 0)
// takes the lowest free slot and reports "listening" with that slot, or "table full"
// with entry 0. A close item (in_tuser 1) frees the given slot and always reports
// "closed"; a slot beyond the table changes nothing. A received packet (in_tuser 2)
// is checked against every slot in ascending order: a listening, not yet bound entry
// whose local port equals the destination port is bound to the packet's source and
// reported as "bound"; a bound entry with delivery enabled whose peer address, peer
// port and local port match yields "deliver" with udp_len minus 8 (0 for short
// datagrams). With no delivery at all, one "port unreachable" with entry 0 follows.
// Kind 3 is dropped without a result. At most 16 results leave per item.
// Timing: one item at a time. The packet scan reads each table entry through a
// registered memory read, in a read state and then an evaluate state, and each bound
// or deliver event adds a state of its own. A listen scan tests the used flags and a
// close needs no scan; any of them waits while the output side stalls. The table
// needs no clearing pass after reset; the controller resets into idle, so in_tready
// is high once reset ends.
module udp_port_demux_table_top #(
  parameter int ENTRIES = udpdmx_pkg::ENTRIES_DEF  // table slots, 1 to 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // input item channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [151:0] in_tdata,   // local_port[15:0], deliver_enable[16], slot[19:17],
                                   // src_ip[51:20], src_mac[99:52], src_port[115:100],
                                   // dst_port[131:116], udp_len[147:132], zero[151:148]
  input  logic [1:0]   in_tuser,   // kind[1:0]
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // entry[2:0], payload_len[18:3], zero[23:19]
  output logic [2:0]   out_tuser,  // event_res[2:0]
  output logic         out_tlast   // last result of the item
);

  udpdmx_pkg::dp_cmd_t cmd;
  udpdmx_pkg::dp_sts_t sts;

  logic [2:0]  res_entry;
  logic [15:0] res_payload_len;

  // Sequence each item: dispatch on kind, step the table scan, drain the last result.
  udpdmx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the table, compare entries and stage results toward the output register.
  udpdmx_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_local_port     (in_tdata[15:0]),
    .in_deliver_enable (in_tdata[16]),
    .in_slot           (in_tdata[19:17]),
    .in_src_ip         (in_tdata[51:20]),
    .in_src_port       (in_tdata[115:100]),
    .in_dst_port       (in_tdata[131:116]),
    .in_udp_len        (in_tdata[147:132]),
    .cmd               (cmd),
    .sts               (sts),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .out_event         (out_tuser),
    .out_entry         (res_entry),
    .out_payload_len   (res_payload_len),
    .out_last          (out_tlast)
  );

  // Pack the result fields, lowest field first, padded to whole bytes.
  assign out_tdata = {5'b0, res_payload_len, res_entry};

endmodule

FILE: hw/rtl/udpdmx_chk.sv
// Port-level checker for the UDP port demultiplexer table, bound to the top level.
module udpdmx_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // an offered item stays offered until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid)
    else $error("input item withdrawn before transfer");

  // reset leaves no result on the channel
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // only deliver events carry a payload length
  a_plen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != udpdmx_pkg::EV_DELIVER) |-> (out_tdata[18:3] == 16'd0))
    else $error("payload length on a non-deliver event");

  // table full and port unreachable always name entry 0, and close each item
  a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == udpdmx_pkg::EV_FULL) ||
                   (out_tuser == udpdmx_pkg::EV_UNREACH))
      |-> (out_tdata[2:0] == 3'd0) && out_tlast)
    else $error("bad entry or last on full or unreachable event");

endmodule

bind udp_port_demux_table_top udpdmx_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: test/testbench.sv
// Self-checking testbench for the UDP port demultiplexer table.
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_SLOTS = udpdmx_pkg::ENTRIES_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;  // dropped by the block, no result
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 60;

  // One input item as the sender sees it; drain_first makes the driver wait until
  // every outstanding result has arrived before offering the item.
  typedef struct {
    logic [1:0]  kind;
    logic [15:0] local_port;
    logic        deliver_en;
    logic [2:0]  slot;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] udp_len;
    logic        drain_first;
  } demux_item_t;

  typedef struct {
    logic [2:0]  ev;
    logic [2:0]  entry;
    logic [15:0] plen;
    logic        last;
  } table_event_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  udp_port_demux_table_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Shadow copy of the endpoint table.
  logic        slot_used  [TABLE_SLOTS];
  logic        slot_bound [TABLE_SLOTS];
  logic        slot_deliv [TABLE_SLOTS];
  logic [15:0] slot_lport [TABLE_SLOTS];
  logic [15:0] slot_pport [TABLE_SLOTS];
  logic [31:0] slot_pip   [TABLE_SLOTS];
  logic [47:0] slot_pmac  [TABLE_SLOTS];

  demux_item_t  item_q[$];      // items waiting to be offered
  table_event_t due_events[$];  // results predicted but not yet seen
  demux_item_t  cur_item;       // item currently on the input channel

  int sent_count = 0;
  int items_accepted = 0;
  int mismatch_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int rx_hold_trigger = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;

  // Traffic pools so that random packets hit the ports that are listened on.
  logic [15:0] port_pool [4];
  logic [31:0] peer_ip_pool [3];
  logic [47:0] peer_mac_pool [3];
  logic [15:0] peer_port_pool [3];

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic table_event_t make_event(logic [2:0] ev, logic [2:0] entry,
                                              logic [15:0] plen);
    table_event_t r;
    r.ev = ev;
    r.entry = entry;
    r.plen = plen;
    r.last = 1'b0;
    return r;
  endfunction

  // Work out the results of one accepted item and advance the shadow table.
  task automatic predict_table_events(input demux_item_t it);
    table_event_t res[$];
    int free_slot;
    logic delivered;
    logic [15:0] plen;
    free_slot = -1;
    delivered = 1'b0;
    plen = (it.udp_len >= udpdmx_pkg::HDR_BYTES) ? it.udp_len - udpdmx_pkg::HDR_BYTES
                                                 : 16'd0;
    if (it.kind == udpdmx_pkg::KIND_LISTEN) begin
      // lowest free slot wins
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) if (!slot_used[i]) free_slot = i;
      if (free_slot >= 0) begin
        slot_used[free_slot] = 1'b1;
        slot_bound[free_slot] = 1'b0;
        slot_deliv[free_slot] = it.deliver_en;
        slot_lport[free_slot] = it.local_port;
        res.push_back(make_event(udpdmx_pkg::EV_LISTEN, free_slot[2:0], 16'd0));
      end else begin
        res.push_back(make_event(udpdmx_pkg::EV_FULL, 3'd0, 16'd0));
      end
    end else if (it.kind == udpdmx_pkg::KIND_CLOSE) begin
      if (it.slot < TABLE_SLOTS) begin
        slot_used[it.slot] = 1'b0;
        slot_bound[it.slot] = 1'b0;
        slot_deliv[it.slot] = 1'b0;
      end
      res.push_back(make_event(udpdmx_pkg::EV_CLOSED, it.slot, 16'd0));
    end else if (it.kind == udpdmx_pkg::KIND_PACKET) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        // bind first, then the freshly bound entry may deliver in the same pass
        if (slot_used[i] && !slot_bound[i] && slot_lport[i] == it.dst_port) begin
          slot_bound[i] = 1'b1;
          slot_pport[i] = it.src_port;
          slot_pip[i] = it.src_ip;
          slot_pmac[i] = it.src_mac;
          res.push_back(make_event(udpdmx_pkg::EV_BOUND, i[2:0], 16'd0));
        end
        if (slot_used[i] && slot_bound[i] && slot_deliv[i] && slot_pip[i] == it.src_ip &&
            slot_pport[i] == it.src_port && slot_lport[i] == it.dst_port) begin
          delivered = 1'b1;
          res.push_back(make_event(udpdmx_pkg::EV_DELIVER, i[2:0], plen));
        end
      end
      if (!delivered) res.push_back(make_event(udpdmx_pkg::EV_UNREACH, 3'd0, 16'd0));
    end
    while (res.size() > udpdmx_pkg::RES_CAP) void'(res.pop_back());
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[k]) due_events.push_back(res[k]);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: check each result transfer against the oldest prediction, then
  // predict the results of any input transfer taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (due_events.size() == 0) begin
          $error("unexpected result: event %0d entry %0d", out_tuser, out_tdata[2:0]);
          mismatch_count++;
        end else begin
          check_field("event_res", 32'(due_events[0].ev), 32'(out_tuser));
          check_field("entry", 32'(due_events[0].entry), 32'(out_tdata[2:0]));
          check_field("payload_len", 32'(due_events[0].plen), 32'(out_tdata[18:3]));
          check_field("last", 32'(due_events[0].last), 32'(out_tlast));
          void'(due_events.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        predict_table_events(cur_item);
        items_accepted++;
      end
    end
  end

  // Driver: offer the next item once the previous transfer is done. Idle only
  // between items; valid stays up until the transfer happens.
  always @(negedge clk) begin
    if (rst_n && sent_count == items_accepted) begin
      if (item_q.size() != 0 && !(item_q[0].drain_first && due_events.size() != 0) &&
          $urandom_range(99) >= snd_idle_pct) begin
        cur_item = item_q.pop_front();
        sent_count++;
        in_tdata <= {4'd0, cur_item.udp_len, cur_item.dst_port, cur_item.src_port,
                     cur_item.src_mac, cur_item.src_ip, cur_item.slot,
                     cur_item.deliver_en, cur_item.local_port};
        in_tuser <= cur_item.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else if (rx_hold_seen != rx_hold_trigger) begin
      rx_hold_seen = rx_hold_trigger;
      rx_hold_left = RX_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  function automatic demux_item_t listen_item(logic [15:0] port, logic den);
    demux_item_t it;
    it = '{default: '0};
    it.kind = udpdmx_pkg::KIND_LISTEN;
    it.local_port = port;
    it.deliver_en = den;
    return it;
  endfunction

  function automatic demux_item_t close_item(logic [2:0] slot);
    demux_item_t it;
    it = '{default: '0};
    it.kind = udpdmx_pkg::KIND_CLOSE;
    it.slot = slot;
    return it;
  endfunction

  function automatic demux_item_t packet_item(logic [31:0] ip, logic [47:0] mac,
                                              logic [15:0] sport, logic [15:0] dport,
                                              logic [15:0] len);
    demux_item_t it;
    it = '{default: '0};
    it.kind = udpdmx_pkg::KIND_PACKET;
    it.src_ip = ip;
    it.src_mac = mac;
    it.src_port = sport;
    it.dst_port = dport;
    it.udp_len = len;
    return it;
  endfunction

  // Queue random items; unused fields carry noise the block must ignore.
  // Dropped kind items do not count toward the total.
  task automatic queue_random_items(input int count);
    demux_item_t it;
    int done;
    int pick;
    int src;
    done = 0;
    while (done < count) begin
      it.local_port = 16'($urandom);
      it.deliver_en = 1'($urandom_range(1));
      it.slot = 3'($urandom_range(7));
      it.src_ip = $urandom;
      it.src_mac = 48'({$urandom, $urandom});
      it.src_port = 16'($urandom);
      it.dst_port = 16'($urandom);
      it.udp_len = 16'($urandom);
      it.drain_first = ($urandom_range(49) == 0);
      pick = $urandom_range(99);
      if (pick < 28) begin
        it.kind = udpdmx_pkg::KIND_LISTEN;
        if ($urandom_range(4) != 0) it.local_port = port_pool[$urandom_range(3)];
      end else if (pick < 48) begin
        it.kind = udpdmx_pkg::KIND_CLOSE;
      end else if (pick < 95) begin
        it.kind = udpdmx_pkg::KIND_PACKET;
        if ($urandom_range(4) != 0) begin
          src = $urandom_range(2);
          it.src_ip = peer_ip_pool[src];
          it.src_mac = peer_mac_pool[src];
          it.src_port = peer_port_pool[src];
        end
        if ($urandom_range(6) != 0) it.dst_port = port_pool[$urandom_range(3)];
        pick = $urandom_range(9);
        if (pick == 0) it.udp_len = 16'($urandom_range(7));
        else if (pick > 1) it.udp_len = 16'($urandom_range(1500, 8));
      end else begin
        it.kind = KIND_UNUSED;
      end
      item_q.push_back(it);
      if (it.kind != KIND_UNUSED) done++;
    end
  endtask

  task automatic wait_items_taken();
    while (item_q.size() != 0 || sent_count != items_accepted) @(posedge clk);
  endtask

  initial begin
    demux_item_t it;
    int n;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_bound[i] = 1'b0;
      slot_deliv[i] = 1'b0;
      slot_lport[i] = '0;
      slot_pport[i] = '0;
      slot_pip[i] = '0;
      slot_pmac[i] = '0;
    end
    foreach (port_pool[i]) port_pool[i] = 16'($urandom);
    port_pool[0] = 16'h1234;
    foreach (peer_ip_pool[i]) begin
      peer_ip_pool[i] = $urandom;
      peer_mac_pool[i] = 48'({$urandom, $urandom});
      peer_port_pool[i] = 16'($urandom);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender idles rarely, receiver often.
    snd_idle_pct = 7;
    rcv_idle_pct = 67;

    // Directed part: empty table, free slot close, full table, widest packet,
    // short datagrams, extreme field values and the dropped kind.
    item_q.push_back(packet_item('0, '0, '0, '0, 16'd0));
    item_q.push_back(close_item(3'd7));
    for (int i = 0; i < TABLE_SLOTS; i++) item_q.push_back(listen_item(16'h1234, 1'b1));
    item_q.push_back(listen_item(16'h5555, 1'b1));
    // every slot binds and delivers: the largest burst of results
    item_q.push_back(packet_item('1, '1, '1, 16'h1234, 16'hFFFF));
    item_q.push_back(packet_item('1, '1, '1, 16'h1234, 16'd8));
    item_q.push_back(packet_item('0, '0, '0, 16'h1234, 16'd7));
    item_q.push_back(close_item(3'd0));
    item_q.push_back(close_item(3'd1));
    item_q.push_back(listen_item(16'h0000, 1'b0));
    item_q.push_back(listen_item(16'hFFFF, 1'b1));
    item_q.push_back(packet_item('0, '0, '0, 16'h0000, 16'd7));
    item_q.push_back(packet_item(32'h1234_5678, 48'hA5A5_0F0F_3C3C, 16'h8001, 16'hFFFF,
                                 16'd100));
    it = '{default: '0};
    it.kind = KIND_UNUSED;
    item_q.push_back(it);
    item_q.push_back(close_item(3'd3));
    item_q.push_back(listen_item(16'h1234, 1'b0));
    item_q.push_back(packet_item('1, '1, '1, 16'h1234, 16'd9));
    queue_random_items(135);
    wait_items_taken();

    // Swap the idling: sender often, receiver rarely.
    snd_idle_pct = 67;
    rcv_idle_pct = 7;
    queue_random_items(135);
    wait_items_taken();

    // No idling; hold the receiver off for a long stretch while the sender keeps
    // offering, and make the first item wait for a fully drained block.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    n = item_q.size();
    queue_random_items(135);
    item_q[n].drain_first = 1'b1;
    rx_hold_trigger++;
    wait_items_taken();

    n = 0;
    while (due_events.size() != 0 && n < DRAIN_LIMIT) begin
      n++;
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_events.size() != 0) begin
      $error("%0d results never arrived", due_events.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
